// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; clk and rst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define CHK_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error(msg);

// check at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) lbl: assert property (@(posedge clk) prop) \
  else $error(msg);

`endif

// ----- sv/fbps_pkg.sv -----
// ----------------------------------------------------------------------------
// Fan button pulse sequencer package
// Item types, configuration bundle and feedback helpers.
// ----------------------------------------------------------------------------
package fbps_pkg;

  typedef struct packed {
    logic       action;
    logic       ms_tick;
    logic [3:0] feedback_lines;
    logic       want_on;
    logic       speed_given;
    logic [2:0] requested_speed;
  } in_item_t;

  typedef struct packed {
    logic       power_line;
    logic [3:0] speed_lines;
    logic       believed_on;
    logic [2:0] believed_speed;
    logic       state_report;
  } out_item_t;

  typedef struct packed {
    logic [15:0] press_ms;
    logic [15:0] gap_ms;
    logic [15:0] settle_ms;
  } cfg_t;

  localparam logic [15:0] PRESS_MS_RST  = 16'd100;
  localparam logic [15:0] GAP_MS_RST    = 16'd300;
  localparam logic [15:0] SETTLE_MS_RST = 16'd1000;
  localparam logic [2:0]  SPEED_RST     = 3'd4;
  localparam logic [2:0]  SPEED_MAX     = 3'd4;

  // highest lit line wins
  function automatic logic [2:0] level_of(input logic [3:0] lines);
    logic [2:0] lvl;
    priority if (lines[3]) lvl = 3'd4;
    else if (lines[2]) lvl = 3'd3;
    else if (lines[1]) lvl = 3'd2;
    else if (lines[0]) lvl = 3'd1;
    else lvl = 3'd0;
    return lvl;
  endfunction

  function automatic logic [3:0] speed_mask(input logic [2:0] cmd);
    logic [3:0] m;
    m = 4'd0;
    if (cmd >= 3'd1 && cmd <= SPEED_MAX) m = 4'd1 << (cmd - 3'd1);
    return m;
  endfunction

endpackage

// ----- sv/fbps_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface fbps_in_if;
  logic               valid;
  logic               ready;
  fbps_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- sv/fbps_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface fbps_out_if;
  logic                valid;
  logic                ready;
  fbps_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- sv/fbps_seq.sv -----
// ----------------------------------------------------------------------------
// Button sequencer core
// Holds the phase, timer and belief state and computes one item's result.
// ----------------------------------------------------------------------------
module fbps_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  fbps_pkg::in_item_t  item,
  input  fbps_pkg::cfg_t      cfg,
  output fbps_pkg::out_item_t result
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_OPERATE   = 4'd1;
  localparam logic [3:0] PH_FEEDBACK  = 4'd2;
  localparam logic [3:0] PH_RELAY_ON  = 4'd3;
  localparam logic [3:0] PH_PWR_HIGH  = 4'd4;
  localparam logic [3:0] PH_PWR_WAIT1 = 4'd5;
  localparam logic [3:0] PH_PWR_LOW   = 4'd6;
  localparam logic [3:0] PH_PWR_WAIT2 = 4'd7;
  localparam logic [3:0] PH_PWR_DONE  = 4'd8;
  localparam logic [3:0] PH_SPD_HIGH  = 4'd9;
  localparam logic [3:0] PH_SPD_WAIT1 = 4'd10;
  localparam logic [3:0] PH_SPD_LOW   = 4'd11;
  localparam logic [3:0] PH_SPD_WAIT2 = 4'd12;
  localparam logic [3:0] PH_RELAY_OFF = 4'd13;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [2:0]  pend_cmd_r, pend_cmd_nxt;
  logic        toggled_r, toggled_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        on_r, on_nxt;
  logic [2:0]  spd_r, spd_nxt;
  logic        pwr_r, pwr_nxt;
  logic [3:0]  btn_r, btn_nxt;
  logic [15:0] elapsed_t;
  logic [2:0]  fb;
  logic        fb_on;
  logic        mis;
  logic        report;

  always_comb begin
    fb        = fbps_pkg::level_of(item.feedback_lines);
    fb_on     = (fb != 3'd0);
    mis       = (on_r != fb_on) || (on_r && (spd_r != fb));
    elapsed_t = (item.ms_tick && elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;

    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    pend_v_nxt   = pend_v_r;
    pend_cmd_nxt = pend_cmd_r;
    toggled_nxt  = toggled_r;
    elapsed_nxt  = elapsed_t;
    on_nxt       = on_r;
    spd_nxt      = spd_r;
    pwr_nxt      = pwr_r;
    btn_nxt      = btn_r;
    report       = 1'b0;

    if (item.action) begin
      on_nxt = item.want_on;
      if (item.want_on) begin
        spd_nxt      = item.speed_given ? item.requested_speed : spd_r;
        pend_cmd_nxt = spd_nxt;
      end else begin
        pend_cmd_nxt = 3'd0;
      end
      pend_v_nxt = 1'b1;
      report     = 1'b1;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (pend_v_r) begin
            cmd_nxt     = pend_cmd_r;
            pend_v_nxt  = 1'b0;
            toggled_nxt = 1'b0;
            phase_nxt   = PH_OPERATE;
          end else if (mis) begin
            elapsed_nxt = 16'd0;
            phase_nxt   = PH_FEEDBACK;
          end
        end
        PH_OPERATE: begin
          if (cmd_r == 3'd0) phase_nxt = fb_on ? PH_RELAY_ON : PH_SPD_HIGH;
          else if (cmd_r <= fbps_pkg::SPEED_MAX) phase_nxt = fb_on ? PH_SPD_HIGH : PH_RELAY_ON;
          else phase_nxt = PH_IDLE;
        end
        PH_FEEDBACK: begin
          if (mis) begin
            if (elapsed_t >= cfg.settle_ms) begin
              on_nxt = fb_on;
              if (fb_on) spd_nxt = fb;
              report    = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_RELAY_ON: phase_nxt = PH_PWR_HIGH;
        PH_PWR_HIGH: begin
          toggled_nxt = 1'b1;
          pwr_nxt     = 1'b1;
          elapsed_nxt = 16'd0;
          phase_nxt   = PH_PWR_WAIT1;
        end
        PH_PWR_WAIT1: if (elapsed_t >= cfg.press_ms) phase_nxt = PH_PWR_LOW;
        PH_PWR_LOW: begin
          pwr_nxt     = 1'b0;
          elapsed_nxt = 16'd0;
          phase_nxt   = PH_PWR_WAIT2;
        end
        PH_PWR_WAIT2: if (elapsed_t >= cfg.gap_ms) phase_nxt = PH_PWR_DONE;
        PH_PWR_DONE: begin
          if (cmd_r == 3'd0 || (cmd_r == fbps_pkg::SPEED_MAX && toggled_r))
            phase_nxt = PH_RELAY_OFF;
          else
            phase_nxt = PH_SPD_HIGH;
        end
        PH_SPD_HIGH: begin
          btn_nxt     = btn_r | fbps_pkg::speed_mask(cmd_r);
          elapsed_nxt = 16'd0;
          phase_nxt   = PH_SPD_WAIT1;
        end
        PH_SPD_WAIT1: if (elapsed_t >= cfg.press_ms) phase_nxt = PH_SPD_LOW;
        PH_SPD_LOW: begin
          btn_nxt     = btn_r & ~fbps_pkg::speed_mask(cmd_r);
          elapsed_nxt = 16'd0;
          phase_nxt   = PH_SPD_WAIT2;
        end
        PH_SPD_WAIT2: if (elapsed_t >= cfg.gap_ms) phase_nxt = PH_RELAY_OFF;
        default: phase_nxt = PH_IDLE;
      endcase
    end

    result.power_line     = pwr_nxt;
    result.speed_lines    = btn_nxt;
    result.believed_on    = on_nxt;
    result.believed_speed = spd_nxt;
    result.state_report   = report;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cmd_r      <= 3'd0;
      pend_v_r   <= 1'b0;
      pend_cmd_r <= 3'd0;
      toggled_r  <= 1'b0;
      elapsed_r  <= 16'd0;
      on_r       <= 1'b0;
      spd_r      <= fbps_pkg::SPEED_RST;
      pwr_r      <= 1'b0;
      btn_r      <= 4'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_cmd_r <= pend_cmd_nxt;
      toggled_r  <= toggled_nxt;
      elapsed_r  <= elapsed_nxt;
      on_r       <= on_nxt;
      spd_r      <= spd_nxt;
      pwr_r      <= pwr_nxt;
      btn_r      <= btn_nxt;
    end
  end

endmodule

// ----- sv/fan_button_pulse_sequencer.sv -----
// ----------------------------------------------------------------------------
// Fan button pulse sequencer
// Input register, sequencer core, result register and configuration registers.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side is not stalled and returns
// exactly one result item for it; the item is held in the input register and
// its result in the result register before the result is valid. Each item
// makes a single pass through the sequencer core between the input register
// and the result register; the input register lets one new item in while the
// previous result waits. Configuration writes take effect on the next item.
module fan_button_pulse_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  fbps_in_if.sink           in_ch,
  fbps_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam logic [1:0] CFG_PRESS  = 2'd0;
  localparam logic [1:0] CFG_GAP    = 2'd1;
  localparam logic [1:0] CFG_SETTLE = 2'd2;

  fbps_pkg::cfg_t      cfg_r;
  fbps_pkg::in_item_t  in_item_r;
  fbps_pkg::out_item_t out_item_r;
  fbps_pkg::out_item_t result;
  logic                in_v_r;
  logic                out_v_r;
  logic                adv;
  logic                step;

  assign adv         = !out_v_r || out_ch.ready;
  assign step        = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_ms  <= fbps_pkg::PRESS_MS_RST;
      cfg_r.gap_ms    <= fbps_pkg::GAP_MS_RST;
      cfg_r.settle_ms <= fbps_pkg::SETTLE_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESS:  cfg_r.press_ms  <= cfg_wdata;
        CFG_GAP:    cfg_r.gap_ms    <= cfg_wdata;
        CFG_SETTLE: cfg_r.settle_ms <= cfg_wdata;
        default:    cfg_r           <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) in_v_r <= 1'b1;
      else if (step) in_v_r <= 1'b0;
      if (step) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_item_r <= in_ch.item;
    if (step) out_item_r <= result;
  end

  fbps_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

endmodule

// ----- sv/fbps_chk.sv -----
// ----------------------------------------------------------------------------
// Fan button pulse sequencer checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbps_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fbps_pkg::out_item_t out_item
);

  `CHK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "stalled item changed")
  `CHK_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result after reset")
  `CHK_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")
  `CHK_ASSERT(a_one_button, out_valid |-> $onehot0(out_item.speed_lines), "two speed buttons held")
  `CHK_ASSERT(a_no_overlap, out_valid && out_item.power_line |-> out_item.speed_lines == 4'd0, "power and speed pressed together")

endmodule

bind fan_button_pulse_sequencer fbps_chk u_fbps_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);

// ----- tb/sv/fbps_checker.sv -----
// ----------------------------------------------------------------------------
// Fan button pulse sequencer checker
// Register index codes shared with the testbench, and a checker that watches
// both channels and the register port, predicts each result and compares.
// ----------------------------------------------------------------------------
package fbps_tb_pkg;

  typedef enum logic [1:0] {
    REG_PRESS_MS  = 2'd0,
    REG_GAP_MS    = 2'd1,
    REG_SETTLE_MS = 2'd2
  } cfg_reg_e;

endpackage

module fbps_checker
  import fbps_pkg::*;
  import fbps_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fbps_in_if          in_ch,
  fbps_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_OPERATE, SEQ_FEEDBACK, SEQ_RELAY_ON,
    SEQ_PWR_HIGH, SEQ_PWR_WAIT1, SEQ_PWR_LOW, SEQ_PWR_WAIT2, SEQ_PWR_DONE,
    SEQ_SPD_HIGH, SEQ_SPD_WAIT1, SEQ_SPD_LOW, SEQ_SPD_WAIT2, SEQ_RELAY_OFF
  } seq_phase_e;

  cfg_t        timing;
  seq_phase_e  seq_phase;
  logic [2:0]  active_cmd;
  logic        queued_valid;
  logic [2:0]  queued_cmd;
  logic        power_toggled;
  logic [15:0] elapsed;
  logic        fan_on;
  logic [2:0]  fan_speed;
  logic        power_drive;
  logic [3:0]  button_drive;
  out_item_t   owed[$];

  function automatic logic [2:0] lit_level(input logic [3:0] lines);
    casez (lines)
      4'b1???: return 3'd4;
      4'b01??: return 3'd3;
      4'b001?: return 3'd2;
      4'b0001: return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [3:0] button_of(input logic [2:0] cmd);
    case (cmd)
      3'd1:    return 4'b0001;
      3'd2:    return 4'b0010;
      3'd3:    return 4'b0100;
      3'd4:    return 4'b1000;
      default: return 4'b0000;
    endcase
  endfunction

  function automatic logic belief_is_off(input logic [2:0] lvl);
    return (fan_on != (lvl != 3'd0)) || (fan_on && fan_speed != lvl);
  endfunction

  function automatic out_item_t advance_sequencer(input in_item_t it);
    logic [2:0] lvl;
    logic       report;
    out_item_t  res;
    lvl    = lit_level(it.feedback_lines);
    report = 1'b0;
    if (it.ms_tick && elapsed != 16'hFFFF) elapsed++;
    if (it.action) begin
      fan_on = it.want_on;
      if (it.want_on) begin
        if (it.speed_given) fan_speed = it.requested_speed;
        queued_cmd = fan_speed;
      end else begin
        queued_cmd = 3'd0;
      end
      queued_valid = 1'b1;
      report       = 1'b1;
    end else begin
      case (seq_phase)
        SEQ_IDLE: begin
          if (queued_valid) begin
            active_cmd    = queued_cmd;
            queued_valid  = 1'b0;
            power_toggled = 1'b0;
            seq_phase     = SEQ_OPERATE;
          end else if (belief_is_off(lvl)) begin
            elapsed   = 16'd0;
            seq_phase = SEQ_FEEDBACK;
          end
        end
        SEQ_OPERATE: begin
          if (active_cmd == 3'd0)
            seq_phase = (lvl != 3'd0) ? SEQ_RELAY_ON : SEQ_SPD_HIGH;
          else if (active_cmd <= 3'd4)
            seq_phase = (lvl == 3'd0) ? SEQ_RELAY_ON : SEQ_SPD_HIGH;
          else
            seq_phase = SEQ_IDLE;
        end
        SEQ_FEEDBACK: begin
          if (!belief_is_off(lvl)) begin
            seq_phase = SEQ_IDLE;
          end else if (elapsed >= timing.settle_ms) begin
            fan_on = (lvl != 3'd0);
            if (fan_on) fan_speed = lvl;
            report    = 1'b1;
            seq_phase = SEQ_IDLE;
          end
        end
        SEQ_RELAY_ON: seq_phase = SEQ_PWR_HIGH;
        SEQ_PWR_HIGH: begin
          power_toggled = 1'b1;
          power_drive   = 1'b1;
          elapsed       = 16'd0;
          seq_phase     = SEQ_PWR_WAIT1;
        end
        SEQ_PWR_WAIT1: if (elapsed >= timing.press_ms) seq_phase = SEQ_PWR_LOW;
        SEQ_PWR_LOW: begin
          power_drive = 1'b0;
          elapsed     = 16'd0;
          seq_phase   = SEQ_PWR_WAIT2;
        end
        SEQ_PWR_WAIT2: if (elapsed >= timing.gap_ms) seq_phase = SEQ_PWR_DONE;
        SEQ_PWR_DONE: begin
          if (active_cmd == 3'd0 || (active_cmd == 3'd4 && power_toggled))
            seq_phase = SEQ_RELAY_OFF;
          else
            seq_phase = SEQ_SPD_HIGH;
        end
        SEQ_SPD_HIGH: begin
          button_drive = button_drive | button_of(active_cmd);
          elapsed      = 16'd0;
          seq_phase    = SEQ_SPD_WAIT1;
        end
        SEQ_SPD_WAIT1: if (elapsed >= timing.press_ms) seq_phase = SEQ_SPD_LOW;
        SEQ_SPD_LOW: begin
          button_drive = button_drive & ~button_of(active_cmd);
          elapsed      = 16'd0;
          seq_phase    = SEQ_SPD_WAIT2;
        end
        SEQ_SPD_WAIT2: if (elapsed >= timing.gap_ms) seq_phase = SEQ_RELAY_OFF;
        default: seq_phase = SEQ_IDLE;
      endcase
    end
    res.power_line     = power_drive;
    res.speed_lines    = button_drive;
    res.believed_on    = fan_on;
    res.believed_speed = fan_speed;
    res.state_report   = report;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      timing.press_ms  = PRESS_MS_RST;
      timing.gap_ms    = GAP_MS_RST;
      timing.settle_ms = SETTLE_MS_RST;
      seq_phase        = SEQ_IDLE;
      active_cmd       = 3'd0;
      queued_valid     = 1'b0;
      queued_cmd       = 3'd0;
      power_toggled    = 1'b0;
      elapsed          = 16'd0;
      fan_on           = 1'b0;
      fan_speed        = SPEED_RST;
      power_drive      = 1'b0;
      button_drive     = 4'd0;
      owed.delete();
      mismatch_count   = 0;
      results_owed    <= 0;
    end else begin
      // retire before predicting: a result never belongs to the item taken now
      if (out_ch.valid && out_ch.ready) begin
        if (owed.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with none expected: pwr=%b spd=%b on=%b lvl=%0d rpt=%b",
                     $time, out_ch.item.power_line, out_ch.item.speed_lines,
                     out_ch.item.believed_on, out_ch.item.believed_speed,
                     out_ch.item.state_report);
        end else begin
          want = owed.pop_front();
          if (out_ch.item.power_line !== want.power_line ||
              out_ch.item.speed_lines !== want.speed_lines ||
              out_ch.item.believed_on !== want.believed_on ||
              out_ch.item.believed_speed !== want.believed_speed ||
              out_ch.item.state_report !== want.state_report) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"%0t: result mismatch: expected pwr=%b spd=%b on=%b lvl=%0d rpt=%b,",
                        " got pwr=%b spd=%b on=%b lvl=%0d rpt=%b"}, $time,
                       want.power_line, want.speed_lines, want.believed_on,
                       want.believed_speed, want.state_report,
                       out_ch.item.power_line, out_ch.item.speed_lines,
                       out_ch.item.believed_on, out_ch.item.believed_speed,
                       out_ch.item.state_report);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) owed.push_back(advance_sequencer(in_ch.item));
      if (cfg_we) begin
        case (cfg_index)
          REG_PRESS_MS:  timing.press_ms  = cfg_wdata;
          REG_GAP_MS:    timing.gap_ms    = cfg_wdata;
          REG_SETTLE_MS: timing.settle_ms = cfg_wdata;
          default: ;
        endcase
      end
      results_owed <= owed.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Fan button pulse sequencer testbench
// Drives directed and random loop passes and commands under several button
// timings, with random gaps on both channels; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import fbps_pkg::*;
  import fbps_tb_pkg::*;

  localparam int      CLK_PERIOD   = 8;
  localparam int      DRAIN_CYCLES = 8;
  localparam longint  TIMEOUT      = 2_000_000;
  localparam int      NUM_FIXED    = 7;
  localparam int      NUM_PHASES   = 9;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int unsigned mismatch_count;
  int unsigned results_owed;

  int unsigned in_run_left  = 0;
  int unsigned out_run_left = 0;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;

  fbps_in_if  in_ch ();
  fbps_out_if out_ch ();

  fan_button_pulse_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fbps_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mix runs of random gaps with runs of back-to-back items
  function automatic int unsigned draw_wait(ref int unsigned run_left, ref bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 48);
      calm     = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [3:0] leds_for_level(input logic [2:0] lvl);
    case (lvl)
      3'd1:    return 4'b0001;
      3'd2:    return 4'b0010;
      3'd3:    return 4'b0100;
      3'd4:    return 4'b1000;
      default: return 4'b0000;
    endcase
  endfunction

  function automatic in_item_t make_item(input logic action, input logic tick,
                                         input logic [3:0] leds, input logic on,
                                         input logic given, input logic [2:0] speed);
    in_item_t it;
    it.action          = action;
    it.ms_tick         = tick;
    it.feedback_lines  = leds;
    it.want_on         = on;
    it.speed_given     = given;
    it.requested_speed = speed;
    return it;
  endfunction

  function automatic in_item_t random_item(input logic [3:0] leds);
    in_item_t it;
    it.action          = ($urandom_range(0, 99) < 7);
    it.ms_tick         = ($urandom_range(0, 9) < 7);
    it.feedback_lines  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : leds;
    it.want_on         = 1'($urandom_range(0, 1));
    it.speed_given     = ($urandom_range(0, 3) != 0);
    it.requested_speed = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                                     : 3'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = draw_wait(in_run_left, in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic set_timing(input logic [15:0] press, input logic [15:0] gap,
                            input logic [15:0] settle);
    drain();
    write_reg(REG_PRESS_MS, press);
    write_reg(REG_GAP_MS, gap);
    write_reg(REG_SETTLE_MS, settle);
    cfg_we <= 1'b0;
  endtask

  // hold ready low for a drawn number of cycles, then take one result
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      int unsigned stall;
      stall = draw_wait(out_run_left, out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned press_tab [NUM_FIXED] = '{100, 0, 1, 65535, 3, 0, 2};
    int unsigned gap_tab   [NUM_FIXED] = '{300, 0, 2, 65535, 1, 65535, 0};
    int unsigned settle_tab[NUM_FIXED] = '{1000, 0, 3, 65535, 6, 0, 1};
    int unsigned count_tab [NUM_PHASES] = '{250, 150, 150, 60, 150, 60, 150, 150, 150};
    in_item_t    it;
    logic [3:0]  leds;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.item   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_PRESS_MS;
    cfg_wdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_timing(16'd0, 16'd0, 16'd0);
    send_item(make_item(1'b0, 1'b0, 4'b0000, 1'b0, 1'b0, 3'd0));
    send_item(make_item(1'b0, 1'b1, 4'b1111, 1'b1, 1'b1, 3'd7));
    send_item(make_item(1'b0, 1'b1, 4'b0001, 1'b0, 1'b0, 3'd0));
    // short dropout: feedback agrees again before settling
    send_item(make_item(1'b0, 1'b0, 4'b0000, 1'b0, 1'b0, 3'd0));
    send_item(make_item(1'b0, 1'b0, 4'b0001, 1'b0, 1'b0, 3'd0));
    // top speed right after a power pulse
    send_item(make_item(1'b1, 1'b1, 4'b1000, 1'b1, 1'b1, 3'd4));
    repeat (8) send_item(make_item(1'b0, 1'b1, 4'b0000, 1'b0, 1'b0, 3'd0));
    // out-of-range speed
    send_item(make_item(1'b1, 1'b0, 4'b0000, 1'b1, 1'b1, 3'd7));
    repeat (2) send_item(make_item(1'b0, 1'b1, 4'b0100, 1'b0, 1'b0, 3'd0));
    // off while already off
    send_item(make_item(1'b1, 1'b0, 4'b0000, 1'b0, 1'b1, 3'd3));
    repeat (6) send_item(make_item(1'b0, 1'b1, 4'b0000, 1'b0, 1'b0, 3'd0));
    // speed zero while on
    send_item(make_item(1'b1, 1'b1, 4'b0010, 1'b1, 1'b1, 3'd0));
    repeat (4) send_item(make_item(1'b0, 1'b0, 4'b0010, 1'b0, 1'b0, 3'd0));
    send_item(make_item(1'b1, 1'b0, 4'b0000, 1'b1, 1'b0, 3'd5));

    leds = 4'b0000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_FIXED)
        set_timing(16'(press_tab[p]), 16'(gap_tab[p]), 16'(settle_tab[p]));
      else
        set_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 6)));
      repeat (count_tab[p]) begin
        if ($urandom_range(0, 24) == 0)
          leds = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : leds_for_level(3'($urandom_range(0, 4)));
        it = random_item(leds);
        // let the fan follow some commands
        if (it.action && $urandom_range(0, 1) == 1)
          leds = it.want_on ? leds_for_level(it.requested_speed) : 4'b0000;
        send_item(it);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("Mismatches found");
    $finish;
  end

endmodule
